>>> src/indexed_ordered_list_core_defines.svh
// ----------------------------------------------------------------------------
// indexed_ordered_list_core_defines
// Assertion macros for the indexed ordered list core.
// The clock and reset are the top level's clk and rst.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ORDERED_LIST_CORE_DEFINES_SVH
`define INDEXED_ORDERED_LIST_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define IOL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("indexed ordered list assertion failed");
`define IOL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("indexed ordered list invariant failed");
`else
`define IOL_ASSERT(lbl, prop)
`define IOL_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> src/iol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_pkg
// Types and codes shared by the indexed ordered list core and its cells.
// ----------------------------------------------------------------------------
package iol_pkg;

  // Widest cell index, set by the largest supported capacity.
  localparam int MAX_AW = 10;

  localparam logic [3:0] KIND_PUSH_FRONT = 4'd0;
  localparam logic [3:0] KIND_PUSH_BACK  = 4'd1;
  localparam logic [3:0] KIND_INSERT     = 4'd2;
  localparam logic [3:0] KIND_GET_FIRST  = 4'd3;
  localparam logic [3:0] KIND_GET_LAST   = 4'd4;
  localparam logic [3:0] KIND_GET_INDEX  = 4'd5;
  localparam logic [3:0] KIND_POP_FRONT  = 4'd6;
  localparam logic [3:0] KIND_POP_BACK   = 4'd7;
  localparam logic [3:0] KIND_POP_INDEX  = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic        [3:0]  kind;
    logic        [7:0]  position;
    logic signed [31:0] data_in;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic        [1:0]  status;
    logic        [6:0]  length;
  } rsp_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic               insert;
    logic               remove;
    logic [MAX_AW-1:0]  at;
    logic signed [31:0] value;
  } cell_ctrl_t;

endpackage

>>> src/iol_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_cell
// One list slot: holds an element and shifts toward either neighbor.
// ----------------------------------------------------------------------------
module iol_cell #(
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  iol_pkg::cell_ctrl_t       ctrl,
  input  logic signed [31:0]        left,
  input  logic signed [31:0]        right,
  output logic signed [31:0]        value,
  output logic signed [31:0]        rd
);

  localparam logic [iol_pkg::MAX_AW-1:0] IDX = iol_pkg::MAX_AW'(INDEX);

  logic signed [31:0] value_next;

  always_comb begin
    value_next = value;
    if (ctrl.insert) begin
      if (IDX > ctrl.at) begin
        value_next = left;
      end else if (IDX == ctrl.at) begin
        value_next = ctrl.value;
      end
    end else if (ctrl.remove) begin
      if (IDX >= ctrl.at) begin
        value_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign rd = (IDX == ctrl.at) ? value : 32'sd0;

endmodule

>>> src/indexed_ordered_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_ordered_list_core
// Ordered list of signed words with push, insert, read and pop by position.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req (kind, position, data_in) with req_valid and
//   req_stall; each gives exactly one response on rsp (data_out, status,
//   length) with rsp_valid and rsp_stall.
//   Every element sits in its own cell of a chain. An insert or removal
//   shifts all cells past the position by one slot in the same cycle, and
//   a read picks the addressed cell.
//   The response is registered and appears in the cycle after accept;
//   throughput is one request per cycle while the receiver takes responses.
//   The response sits in an output register. While it is held by rsp_stall
//   the core stalls new requests; once it is taken, the next request is
//   accepted in that same cycle.
//   Reset empties the list at once; the cell contents are not cleared, as
//   nothing past the length is ever read.
// ----------------------------------------------------------------------------
`include "indexed_ordered_list_core_defines.svh"

module indexed_ordered_list_core #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  iol_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output iol_pkg::rsp_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > 9) ? CW : 9;

  logic [CW-1:0]             cnt;
  logic [CW-1:0]             cnt_next;
  logic                      accept;
  logic                      full;
  logic                      empty;
  logic [MW-1:0]             cnt_ext;
  logic [MW-1:0]             pos_ext;
  logic [MW-1:0]             pos_plus;
  logic [1:0]                st;
  logic [iol_pkg::MAX_AW-1:0] at;
  logic                      ins;
  logic                      rem;
  logic                      rd_en;
  logic signed [31:0]        rd_val;
  iol_pkg::cell_ctrl_t       ctrl;
  logic signed [31:0]        cell_val [CAPACITY];
  logic signed [31:0]        cell_rd  [CAPACITY];

  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;
  assign full      = (cnt == CW'(CAPACITY));
  assign empty     = (cnt == '0);
  assign cnt_ext   = MW'(cnt);
  assign pos_ext   = MW'(req.position);
  assign pos_plus  = pos_ext + MW'(1);

  always_comb begin
    st    = iol_pkg::ST_OK;
    at    = '0;
    ins   = 1'b0;
    rem   = 1'b0;
    rd_en = 1'b0;
    case (req.kind)
      iol_pkg::KIND_PUSH_FRONT, iol_pkg::KIND_PUSH_BACK, iol_pkg::KIND_INSERT: begin
        if (full) begin
          st = iol_pkg::ST_FULL;
        end else begin
          ins = 1'b1;
          if (req.kind == iol_pkg::KIND_PUSH_FRONT) begin
            at = '0;
          end else if (req.kind == iol_pkg::KIND_PUSH_BACK) begin
            at = iol_pkg::MAX_AW'(cnt);
          end else begin
            // Past the last element the value simply goes at the end.
            at = (pos_plus < cnt_ext) ? iol_pkg::MAX_AW'(pos_plus)
                                      : iol_pkg::MAX_AW'(cnt);
          end
        end
      end
      iol_pkg::KIND_GET_FIRST, iol_pkg::KIND_GET_LAST, iol_pkg::KIND_GET_INDEX,
      iol_pkg::KIND_POP_FRONT, iol_pkg::KIND_POP_BACK, iol_pkg::KIND_POP_INDEX: begin
        if (empty) begin
          st = iol_pkg::ST_EMPTY;
        end else if (req.kind inside {iol_pkg::KIND_GET_FIRST, iol_pkg::KIND_POP_FRONT}) begin
          at    = '0;
          rd_en = 1'b1;
        end else if (req.kind inside {iol_pkg::KIND_GET_LAST, iol_pkg::KIND_POP_BACK}) begin
          at    = iol_pkg::MAX_AW'(cnt - CW'(1));
          rd_en = 1'b1;
        end else if (pos_ext < cnt_ext) begin
          at    = iol_pkg::MAX_AW'(pos_ext);
          rd_en = 1'b1;
        end else begin
          st = iol_pkg::ST_RANGE;
        end
        rem = rd_en & (req.kind inside {iol_pkg::KIND_POP_FRONT, iol_pkg::KIND_POP_BACK,
                                        iol_pkg::KIND_POP_INDEX});
      end
      default: begin
        st = iol_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    if (ins) begin
      cnt_next = cnt + CW'(1);
    end else if (rem) begin
      cnt_next = cnt - CW'(1);
    end else begin
      cnt_next = cnt;
    end
  end

  assign ctrl.insert = ins & accept;
  assign ctrl.remove = rem & accept;
  assign ctrl.at     = at;
  assign ctrl.value  = req.data_in;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left;
    logic signed [31:0] right;
    if (i == 0) begin : g_first
      assign left = 32'sd0;
    end else begin : g_mid_l
      assign left = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = 32'sd0;
    end else begin : g_mid_r
      assign right = cell_val[i+1];
    end
    iol_cell #(
      .INDEX (i)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left),
      .right (right),
      .value (cell_val[i]),
      .rd    (cell_rd[i])
    );
  end

  // Only the addressed cell drives a nonzero read word.
  always_comb begin
    rd_val = 32'sd0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_val = rd_val | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.data_out <= rd_en ? rd_val : 32'sd0;
      rsp.status   <= st;
      rsp.length   <= 7'(cnt_next);
    end
  end

  `IOL_ASSERT_ALWAYS(a_cnt_bound, rst || (cnt <= CW'(CAPACITY)))
  `IOL_ASSERT(a_rsp_follows, accept |=> rsp_valid)
  `IOL_ASSERT(a_len_tracks, accept |=> (rsp.length == 7'(cnt)))
  `IOL_ASSERT(a_full_holds, (accept && st == iol_pkg::ST_FULL) |=> full)

endmodule
